[rtl/core/stuffed_frame_receiver_defines.svh]
// assertion macros used by the receiver top level
`ifndef STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfr assertion failed");

// expression must never be true outside reset
`define SFR_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sfr forbidden condition seen");

`else

`define SFR_ASSERT(label, clk, rst_n, prop)
`define SFR_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[rtl/core/sfr_pkg.sv]
package sfr_pkg;

    localparam logic [7:0]  MARKER_BYTE     = 8'h5A;
    localparam logic [7:0]  ESCAPE_BYTE     = 8'h5B;
    localparam logic [7:0]  ESC_CODE_MARKER = 8'h01;
    localparam logic [7:0]  ESC_CODE_ESCAPE = 8'h02;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [15:0] HEADER_BYTES    = 16'd2;
    localparam logic [15:0] MIN_PAYLOAD     = 16'd4;
    localparam logic [16:0] LENGTH_EXTRA    = 17'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LEN   = 2'd2,
        ST_SUM   = 2'd3
    } t_status;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_rec;

    // up to two results handed to the output queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    // output queue status seen by the top level
    typedef struct packed {
        logic [FIFO_AW:0] level;
        logic             can_take;
    } t_fifo_stat;

    typedef struct packed {
        logic        in_frame;
        logic        esc;
        logic [15:0] count;
        logic [15:0] decl_len;
        logic [7:0]  sum;
        logic [7:0]  held;
        logic        held_valid;
    } t_frame_state;

    typedef struct packed {
        t_frame_state st;
        logic         emit;
        logic [7:0]   data;
    } t_take;

endpackage

[rtl/core/sfr_deframe.sv]
module sfr_deframe
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    t_frame_state r_st, n_st;

    // one unescaped payload byte into the frame state
    function automatic t_take take_payload(t_frame_state s, logic [7:0] b);
        t_take t;
        t      = '0;
        t.st   = s;
        if (s.count < HEADER_BYTES) begin
            t.st.decl_len = {s.decl_len[7:0], b};
            t.st.sum      = s.sum + b;
        end else begin
            if (s.held_valid) begin
                t.emit   = 1'b1;
                t.data   = s.held;
                t.st.sum = s.sum + s.held;
            end
            t.st.held       = b;
            t.st.held_valid = 1'b1;
        end
        if (s.count != COUNT_MAX) begin
            t.st.count = s.count + 16'd1;
        end
        return t;
    endfunction

    t_frame_state s0, s1, s2;
    t_take        t1, t2;
    logic         en1, en2, close;
    logic [7:0]   a1;
    t_status      status;
    t_rec         d1, d2, er;
    logic         e1, e2;

    always_comb begin
        s0    = r_st;
        en1   = 1'b0;
        en2   = 1'b0;
        a1    = ESCAPE_BYTE;
        close = 1'b0;

        if (!r_st.in_frame) begin
            if (i_byte == MARKER_BYTE) begin
                s0          = '0;
                s0.in_frame = 1'b1;
            end
        end else if (i_byte == MARKER_BYTE) begin
            // dangling escape before the closing marker is a literal 5b
            close  = 1'b1;
            en1    = r_st.esc;
            s0.esc = 1'b0;
        end else if (r_st.esc) begin
            en1    = 1'b1;
            a1     = (i_byte == ESC_CODE_MARKER) ? MARKER_BYTE : ESCAPE_BYTE;
            en2    = (i_byte != ESC_CODE_MARKER) && (i_byte != ESC_CODE_ESCAPE)
                     && (i_byte != ESCAPE_BYTE);
            s0.esc = (i_byte == ESCAPE_BYTE);
        end else if (i_byte == ESCAPE_BYTE) begin
            s0.esc = 1'b1;
        end else begin
            en1 = 1'b1;
            a1  = i_byte;
        end

        t1 = take_payload(s0, a1);
        s1 = en1 ? t1.st : s0;
        t2 = take_payload(s1, i_byte);
        s2 = en2 ? t2.st : s1;

        priority if (s2.count < MIN_PAYLOAD) begin
            status = ST_SHORT;
        end else if ({1'b0, s2.decl_len} != ({1'b0, s2.count} + LENGTH_EXTRA)) begin
            status = ST_LEN;
        end else if (s2.sum != s2.held) begin
            status = ST_SUM;
        end else begin
            status = ST_OK;
        end

        if (close) begin
            s2.in_frame = 1'b0;
        end

        e1 = en1 & t1.emit;
        e2 = en2 & t2.emit;
        d1 = '{data: t1.data, last: 1'b0, status: ST_OK};
        d2 = '{data: t2.data, last: 1'b0, status: ST_OK};
        er = '{data: 8'h00, last: 1'b1, status: status};

        // pack the results into the lowest slots, in order
        o_push = '0;
        if (i_fire) begin
            if (e1) begin
                o_push.rec0 = d1;
                o_push.rec1 = e2 ? d2 : er;
                o_push.n    = 2'd1 + {1'b0, (e2 | close)};
            end else if (e2) begin
                o_push.rec0 = d2;
                o_push.rec1 = er;
                o_push.n    = 2'd1 + {1'b0, close};
            end else begin
                o_push.rec0 = er;
                o_push.rec1 = er;
                o_push.n    = {1'b0, close};
            end
        end

        n_st = i_fire ? s2 : r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

[rtl/core/sfr_out_fifo.sv]
module sfr_out_fifo
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output t_rec       o_head,
    output t_fifo_stat o_stat
);

    t_rec                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, n_wp;
    logic [FIFO_AW-1:0]  r_rp, n_rp;
    logic [FIFO_AW:0]    r_level, n_level;
    logic [FIFO_AW-1:0]  wp1;

    always_comb begin
        wp1     = r_wp + FIFO_AW'(1);
        n_wp    = r_wp + i_push.n[FIFO_AW-1:0];
        n_rp    = r_rp + FIFO_AW'(i_pop);
        n_level = r_level + (FIFO_AW+1)'(i_push.n) - (FIFO_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.rec0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp1] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    assign o_head          = r_mem[r_rp];
    assign o_stat.level    = r_level;
    // room for two results, whatever the consumer does this cycle
    assign o_stat.can_take = (r_level <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

endmodule

[rtl/core/stuffed_frame_receiver.sv]
// stuffed_frame_receiver: byte-stuffed frame deframer with additive checksum
// path: an accepted line byte is registered in the input register, then its results are written to the result queue
// throughput: one line byte per cycle while the message side keeps up; the input
//   stalls whenever more than two results wait in the four-entry result queue
// reset: i_rst_n synchronous active low; hunting for a marker, queue empty,
//   line side not ready while reset is held
`include "stuffed_frame_receiver_defines.svh"

module stuffed_frame_receiver
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // line side
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    // message side
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // frame_end, closes a frame with its status
    output logic [1:0] o_m_tuser    // [1:0] frame_status
);

    // input register: one line byte waiting for the deframer
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    logic       proc_fire;
    logic       s_accept;
    logic       m_pop;
    t_push      push;
    t_rec       head;
    t_fifo_stat fstat;

    // a held byte moves on once the queue can take both of its possible results
    assign proc_fire  = r_in_valid & fstat.can_take;
    assign o_s_tready = i_rst_n & (~r_in_valid | proc_fire);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign n_in_valid = s_accept | (r_in_valid & ~proc_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // marker hunt, unescape, length and checksum tracking
    sfr_deframe u_deframe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    // result queue, parts the deframer from a stalling consumer
    sfr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_pop),
        .o_head  (head),
        .o_stat  (fstat)
    );

    assign o_m_tvalid = (fstat.level != '0);
    assign m_pop      = o_m_tvalid & i_m_tready;
    assign o_m_tdata  = head.data;
    assign o_m_tlast  = head.last;
    assign o_m_tuser  = head.status;

    // queue never overfills
    `SFR_ASSERT_NEVER(a_level_bound, i_clk, i_rst_n, fstat.level > (FIFO_AW+1)'(FIFO_DEPTH))

    // results only ever pushed while the queue had room for two
    `SFR_ASSERT(a_push_room, i_clk, i_rst_n, (push.n != 2'd0) |-> fstat.can_take)

    // a data item carries no status
    `SFR_ASSERT(a_data_status, i_clk, i_rst_n, (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser == ST_OK))

    // a byte held back by a queue without room for two results is still there next cycle
    `SFR_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !proc_fire) |=> r_in_valid)

endmodule
